### sv/tpdq_pkg.sv
// Shared types, codes and reset values for the timed packet delay queue.
package tpdq_pkg;

  localparam int unsigned TagW    = 16;
  localparam int unsigned TimeW   = 32;
  localparam int unsigned DelayW  = 17;
  localparam int unsigned CapW    = 13;
  localparam int unsigned FlushW  = 7;
  localparam int unsigned HeldW   = 13;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDatW = 17;

  localparam logic [DelayW-1:0] DelayReset = DelayW'(4800);

  typedef enum logic [1:0] {
    OP_PACKET = 2'd0,
    OP_TICK   = 2'd1,
    OP_DRAIN  = 2'd2,
    OP_SPARE  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    CAUSE_PASS   = 2'd0,
    CAUSE_EXPIRE = 2'd1,
    CAUSE_FLUSH  = 2'd2,
    CAUSE_DRAIN  = 2'd3
  } cause_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_DELAY_MS       = 3'd0,
    REG_CAPACITY       = 3'd1,
    REG_FLUSH_COUNT    = 3'd2,
    REG_DELAY_INBOUND  = 3'd3,
    REG_DELAY_OUTBOUND = 3'd4
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PASS,
    ST_EXPIRE,
    ST_FLUSH,
    ST_DRAIN,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic [DelayW-1:0] delay_ms;
    logic [CapW-1:0]   capacity;
    logic [FlushW-1:0] flush_count;
    logic              delay_inbound;
    logic              delay_outbound;
  } cfg_t;

endpackage

### sv/tpdq_cfg.sv
// Configuration register file of the timed packet delay queue.
module tpdq_cfg
  import tpdq_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               wr_en_i,
  input  logic [CfgIdxW-1:0] wr_index_i,
  input  logic [CfgDatW-1:0] wr_data_i,
  output cfg_t               cfg_o
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.delay_ms       <= DelayReset;
      cfg_q.capacity       <= '0;
      cfg_q.flush_count    <= '0;
      cfg_q.delay_inbound  <= 1'b1;
      cfg_q.delay_outbound <= 1'b1;
    end else if (wr_en_i) begin
      unique case (wr_index_i)
        REG_DELAY_MS:       cfg_q.delay_ms       <= wr_data_i[DelayW-1:0];
        REG_CAPACITY:       cfg_q.capacity       <= wr_data_i[CapW-1:0];
        REG_FLUSH_COUNT:    cfg_q.flush_count    <= wr_data_i[FlushW-1:0];
        REG_DELAY_INBOUND:  cfg_q.delay_inbound  <= wr_data_i[0];
        REG_DELAY_OUTBOUND: cfg_q.delay_outbound <= wr_data_i[0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

### sv/timed_packet_delay_queue_core.sv
// Top level of the timed packet delay queue: descriptor memory and release sequencer.
// Results leave the sequencer one per cycle while the output does not stall; each is held in
// a pending register and then moves to the output register.
// The input stalls until the sequencer returns to idle, so an item is taken only after the last
// is done; the one-read-port memory releases the oldest entry at one per cycle without stalls.
// Reset: pointers, held count and control clear at once; the memory is not cleared.
module timed_packet_delay_queue_core
  import tpdq_pkg::*;
#(
  parameter int unsigned DEPTH     = 4096,
  parameter int unsigned TAG_BITS  = 16,
  parameter int unsigned MAX_BURST = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CfgDatW-1:0] cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         op_i,
  input  logic [TagW-1:0]    packet_tag_i,
  input  logic               outbound_i,
  input  logic [TimeW-1:0]   now_ms_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [TagW-1:0]    packet_tag_res_o,
  output logic [1:0]         cause_o,
  output logic [HeldW-1:0]   held_count_o,
  output logic               last_o
);

  localparam int unsigned TW  = (TAG_BITS < TagW) ? TAG_BITS : TagW;
  localparam int unsigned PW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned HW  = $clog2(DEPTH + 1);
  localparam int unsigned CW  = (HW > CapW) ? HW : CapW;
  localparam int unsigned NW  = $clog2(MAX_BURST + 1);
  localparam int unsigned MW  = TW + TimeW;

  cfg_t cfg;

  tpdq_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i && cfg_ready_o),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  assign cfg_ready_o = 1'b1;

  state_e            state_q, state_d;
  logic [PW-1:0]     rp_q, wp_q;
  logic [HW-1:0]     held_q;
  logic [NW-1:0]     n_q;
  logic [FlushW-1:0] k_q;
  logic              fwd_q;
  logic [TW-1:0]     tag_q;
  logic [TimeW-1:0]  now_q;
  logic              pend_v_q;
  logic [TagW-1:0]   pend_tag_q;
  logic [1:0]        pend_cause_q;
  logic [HeldW-1:0]  pend_held_q;
  logic              out_valid_q;
  logic [TagW-1:0]   out_tag_q;
  logic [1:0]        out_cause_q;
  logic [HeldW-1:0]  out_held_q;
  logic              out_last_q;

  logic [MW-1:0]     mem [DEPTH];
  logic [MW-1:0]     rd_q;
  logic [PW-1:0]     rd_addr;

  logic              accept, capture, enabled, push_ok, can_go;
  logic              room, expire, full, produce, release_c, final_push;
  logic [CW-1:0]     cap_c, held_ext;
  logic [TW-1:0]     rd_tag;
  logic [TimeW-1:0]  rd_time, age;
  logic [TagW-1:0]   prod_tag;
  cause_e            prod_cause;
  logic [HeldW-1:0]  prod_held;

  function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign accept   = in_valid_i && !in_stall_o;
  assign enabled  = outbound_i ? cfg.delay_outbound : cfg.delay_inbound;
  assign cap_c    = (CW'(cfg.capacity) > CW'(DEPTH)) ? CW'(DEPTH) : CW'(cfg.capacity);
  assign held_ext = CW'(held_q);
  assign capture  = (op_e'(op_i) == OP_PACKET) && enabled && (held_ext < cap_c);
  assign full     = held_ext >= cap_c;

  assign push_ok  = !out_valid_q || !out_stall_i;
  assign can_go   = !pend_v_q || push_ok;

  assign rd_tag   = fwd_q ? tag_q : rd_q[MW-1:TimeW];
  assign rd_time  = fwd_q ? now_q : rd_q[TimeW-1:0];
  assign age      = now_q - rd_time;
  assign expire   = age > TimeW'(cfg.delay_ms);
  assign room     = (held_q != '0) && (n_q < NW'(MAX_BURST));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (op_e'(op_i) == OP_DRAIN) begin
            state_d = ST_DRAIN;
          end else if ((op_e'(op_i) == OP_PACKET) && !capture) begin
            state_d = ST_PASS;
          end else begin
            state_d = ST_EXPIRE;
          end
        end
      end
      ST_PASS: begin
        if (can_go) state_d = ST_EXPIRE;
      end
      ST_EXPIRE: begin
        if (!(room && expire)) state_d = full ? ST_FLUSH : ST_FINISH;
      end
      ST_FLUSH: begin
        if (!(room && (k_q != '0))) state_d = ST_FINISH;
      end
      ST_DRAIN: begin
        if (!room) state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (can_go) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    produce    = 1'b0;
    prod_cause = CAUSE_PASS;
    final_push = 1'b0;
    unique case (state_q)
      ST_PASS: begin
        produce = can_go;
      end
      ST_EXPIRE: begin
        produce    = can_go && room && expire;
        prod_cause = CAUSE_EXPIRE;
      end
      ST_FLUSH: begin
        produce    = can_go && room && (k_q != '0);
        prod_cause = CAUSE_FLUSH;
      end
      ST_DRAIN: begin
        produce    = can_go && room;
        prod_cause = CAUSE_DRAIN;
      end
      ST_FINISH: begin
        final_push = pend_v_q && push_ok;
      end
      default: ;
    endcase
  end

  assign in_stall_o = (state_q != ST_IDLE);
  assign release_c  = produce && (state_q != ST_PASS);
  assign prod_tag   = (state_q == ST_PASS) ? TagW'(tag_q) : TagW'(rd_tag);
  assign prod_held  = release_c ? HeldW'(held_ext - 1'b1) : HeldW'(held_ext);
  assign rd_addr    = release_c ? ptr_next(rp_q) : rp_q;

  always_ff @(posedge clk_i) begin
    if (accept && capture) mem[wp_q] <= {packet_tag_i[TW-1:0], now_ms_i};
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      tag_q <= packet_tag_i[TW-1:0];
      now_q <= now_ms_i;
    end
    if (produce) begin
      pend_tag_q   <= prod_tag;
      pend_cause_q <= prod_cause;
      pend_held_q  <= prod_held;
    end
    if (final_push || (produce && pend_v_q)) begin
      out_tag_q   <= pend_tag_q;
      out_cause_q <= pend_cause_q;
      out_held_q  <= pend_held_q;
      out_last_q  <= final_push;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rp_q        <= '0;
      wp_q        <= '0;
      held_q      <= '0;
      n_q         <= '0;
      k_q         <= '0;
      fwd_q       <= 1'b0;
      pend_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      fwd_q   <= accept && capture && (held_q == '0);
      if (accept) begin
        n_q <= '0;
        k_q <= cfg.flush_count;
      end else if (produce) begin
        n_q <= n_q + 1'b1;
        if (state_q == ST_FLUSH) k_q <= k_q - 1'b1;
      end
      if (accept && capture) begin
        wp_q   <= ptr_next(wp_q);
        held_q <= held_q + 1'b1;
      end else if (release_c) begin
        rp_q   <= ptr_next(rp_q);
        held_q <= held_q - 1'b1;
      end
      if (produce) begin
        pend_v_q <= 1'b1;
      end else if (final_push) begin
        pend_v_q <= 1'b0;
      end
      if (final_push || (produce && pend_v_q)) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign packet_tag_res_o = out_tag_q;
  assign cause_o          = out_cause_q;
  assign held_count_o     = out_held_q;
  assign last_o           = out_last_q;

  a_held_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q <= HW'(DEPTH))
    else $error("held count above depth");

  a_empty_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (held_q == '0) |-> (rp_q == wp_q))
    else $error("empty queue with pointers apart");

  a_burst_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= NW'(MAX_BURST))
    else $error("result count above burst limit");

  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !pend_v_q)
    else $error("result left pending at idle");

endmodule

### verif/testbench.sv
// Self-checking testbench: predicts delay queue releases and checks each output transfer.
`timescale 1ns / 100ps
module testbench;
  import tpdq_pkg::*;

  localparam int unsigned QueueDepth    = 4096;
  localparam int unsigned BurstLimit    = 64;
  localparam int unsigned SettleCycles  = 8;
  localparam int unsigned LongHold      = 400;
  localparam int unsigned WatchdogLimit = 4000;

  typedef struct packed {
    logic [TagW-1:0]  tag;
    cause_e           cause;
    logic [HeldW-1:0] held;
    logic             last;
  } release_t;

  logic               clk_i        = 1'b0;
  logic               rst_ni       = 1'b0;
  logic               cfg_valid_i  = 1'b0;
  logic [CfgIdxW-1:0] cfg_index_i  = '0;
  logic [CfgDatW-1:0] cfg_data_i   = '0;
  logic               in_valid_i   = 1'b0;
  logic [1:0]         op_i         = '0;
  logic [TagW-1:0]    packet_tag_i = '0;
  logic               outbound_i   = 1'b0;
  logic [TimeW-1:0]   now_ms_i     = '0;
  logic               out_stall_i  = 1'b0;
  logic               cfg_ready_o;
  logic               in_stall_o;
  logic               out_valid_o;
  logic [TagW-1:0]    packet_tag_res_o;
  logic [1:0]         cause_o;
  logic [HeldW-1:0]   held_count_o;
  logic               last_o;

  release_t         release_q[$];
  logic [TagW-1:0]  tag_mem   [QueueDepth];
  logic [TimeW-1:0] stamp_mem [QueueDepth];
  int unsigned      oldest_idx, next_idx, held_n, burst_n;
  cfg_t             cfg_shadow;

  int unsigned      send_idle_pct, recv_stall_pct;
  bit               hold_trigger, hold_seen;
  int unsigned      hold_left, idle_cycles;
  int unsigned      items_sent, releases_seen, reg_writes, mismatches;
  logic [TimeW-1:0] clock_ms;

  timed_packet_delay_queue_core #(
    .DEPTH    (QueueDepth),
    .TAG_BITS (TagW),
    .MAX_BURST(BurstLimit)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .op_i            (op_i),
    .packet_tag_i    (packet_tag_i),
    .outbound_i      (outbound_i),
    .now_ms_i        (now_ms_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .packet_tag_res_o(packet_tag_res_o),
    .cause_o         (cause_o),
    .held_count_o    (held_count_o),
    .last_o          (last_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic void queue_release(logic [TagW-1:0] tag, cause_e cause);
    release_t r;
    r.tag   = tag;
    r.cause = cause;
    r.held  = HeldW'(held_n);
    r.last  = 1'b0;
    release_q.push_back(r);
    burst_n++;
  endfunction

  function automatic void release_oldest(cause_e cause);
    logic [TagW-1:0] tag;
    tag        = tag_mem[oldest_idx];
    oldest_idx = (oldest_idx + 1) % QueueDepth;
    held_n--;
    queue_release(tag, cause);
  endfunction

  function automatic void predict_releases(op_e op, logic [TagW-1:0] tag, logic outb,
                                           logic [TimeW-1:0] now);
    int unsigned      cap;
    int unsigned      left;
    logic             enabled;
    logic [TimeW-1:0] age;
    cap     = (cfg_shadow.capacity > QueueDepth) ? QueueDepth : cfg_shadow.capacity;
    burst_n = 0;
    if (op == OP_DRAIN) begin
      while (held_n > 0 && burst_n < BurstLimit) release_oldest(CAUSE_DRAIN);
    end else begin
      if (op == OP_PACKET) begin
        enabled = outb ? cfg_shadow.delay_outbound : cfg_shadow.delay_inbound;
        if (enabled && held_n < cap) begin
          tag_mem[next_idx]   = tag;
          stamp_mem[next_idx] = now;
          next_idx            = (next_idx + 1) % QueueDepth;
          held_n++;
        end else begin
          queue_release(tag, CAUSE_PASS);
        end
      end
      while (held_n > 0 && burst_n < BurstLimit) begin
        age = now - stamp_mem[oldest_idx];
        if (age <= TimeW'(cfg_shadow.delay_ms)) break;
        release_oldest(CAUSE_EXPIRE);
      end
      if (held_n >= cap) begin
        left = cfg_shadow.flush_count;
        while (left > 0 && held_n > 0 && burst_n < BurstLimit) begin
          release_oldest(CAUSE_FLUSH);
          left--;
        end
      end
    end
    if (burst_n > 0) release_q[release_q.size() - 1].last = 1'b1;
  endfunction

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    mismatches++;
    if (mismatches <= 50) begin
      $display("[%0t] MISMATCH %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    end
  endtask

  task automatic set_idling(int unsigned send_pct, int unsigned recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  task automatic send_item(op_e op, logic [TagW-1:0] tag, logic outb, logic [TimeW-1:0] now);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    op_i         <= op;
    packet_tag_i <= tag;
    outbound_i   <= outb;
    now_ms_i     <= now;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    items_sent++;
    predict_releases(op, tag, outb, now);
  endtask

  task automatic send_packet(logic outb, logic [TimeW-1:0] now);
    send_item(OP_PACKET, TagW'($urandom_range(0, 65535)), outb, now);
  endtask

  task automatic send_control(op_e op, logic [TimeW-1:0] now);
    send_item(op, TagW'($urandom_range(0, 65535)), 1'($urandom_range(1)), now);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (release_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_idx_e idx, int unsigned value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= CfgDatW'(value);
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    reg_writes++;
  endtask

  task automatic configure(int unsigned delay, int unsigned cap, int unsigned flush,
                           bit inb, bit outb);
    settle();
    write_reg(REG_DELAY_MS, delay);
    write_reg(REG_CAPACITY, cap);
    write_reg(REG_FLUSH_COUNT, flush);
    write_reg(REG_DELAY_INBOUND, inb);
    write_reg(REG_DELAY_OUTBOUND, outb);
    cfg_valid_i <= 1'b0;
    cfg_shadow.delay_ms       = DelayW'(delay);
    cfg_shadow.capacity       = CapW'(cap);
    cfg_shadow.flush_count    = FlushW'(flush);
    cfg_shadow.delay_inbound  = inb;
    cfg_shadow.delay_outbound = outb;
  endtask

  task automatic test_reset_defaults();
    set_idling(23, 85);
    send_item(OP_PACKET, 16'h0000, 1'b0, 32'h0000_0000);
    send_item(OP_PACKET, 16'hFFFF, 1'b1, 32'hFFFF_FFFF);
    send_control(OP_TICK, 32'h0000_1000);
    send_control(OP_DRAIN, 32'h0000_2000);
    send_control(OP_SPARE, 32'h0000_3000);
  endtask

  task automatic test_expiry();
    logic [TimeW-1:0] t;
    t = 32'hFFFF_FFF8;
    configure(10, 8, 0, 1'b1, 1'b1);
    send_packet(1'b0, t);
    send_packet(1'b1, t + 2);
    send_control(OP_TICK, t + 10);
    send_control(OP_TICK, t + 11);
    send_control(OP_TICK, t + 12);
    send_control(OP_SPARE, t + 13);
    configure(0, 4, 0, 1'b1, 1'b1);
    send_packet(1'b0, 32'd100);
    send_control(OP_TICK, 32'd100);
    send_control(OP_SPARE, 32'd101);
    configure(99999, 4, 0, 1'b1, 1'b1);
    send_packet(1'b1, 32'd0);
    send_control(OP_TICK, 32'd99999);
    send_control(OP_TICK, 32'd100000);
  endtask

  task automatic test_directions();
    configure(1000, 8, 0, 1'b0, 1'b1);
    send_packet(1'b0, 32'd50);
    send_packet(1'b1, 32'd50);
    configure(1000, 8, 0, 1'b1, 1'b0);
    send_packet(1'b0, 32'd60);
    send_packet(1'b1, 32'd60);
    send_control(OP_DRAIN, 32'd70);
  endtask

  task automatic test_flush();
    configure(99999, 4, 2, 1'b1, 1'b1);
    repeat (6) send_packet(1'($urandom_range(1)), 32'd0);
    configure(99999, 4, 64, 1'b1, 1'b1);
    repeat (2) send_packet(1'b1, 32'd0);
    configure(99999, 2, 0, 1'b1, 1'b1);
    repeat (3) send_packet(1'b0, 32'd0);
    send_control(OP_TICK, 32'd1);
    configure(99999, 1, 1, 1'b1, 1'b1);
    send_control(OP_TICK, 32'd2);
    send_packet(1'b1, 32'd3);
    configure(99999, 0, 3, 1'b1, 1'b1);
    send_packet(1'b0, 32'd4);
  endtask

  task automatic test_burst_limit();
    set_idling(0, 0);
    configure(5, 100, 0, 1'b1, 1'b1);
    repeat (66) send_packet(1'($urandom_range(1)), 32'd1000);
    send_control(OP_TICK, 32'd1006);
    send_control(OP_TICK, 32'd1006);
    repeat (66) send_packet(1'($urandom_range(1)), 32'd2000);
    send_control(OP_DRAIN, 32'd2001);
    send_control(OP_DRAIN, 32'd2001);
  endtask

  task automatic test_large_capacity();
    set_idling(0, 0);
    configure(99999, 6000, 64, 1'b1, 1'b1);
    repeat (20) send_packet(1'($urandom_range(1)), 32'd0);
    send_control(OP_TICK, 32'd5);
    while (held_n > 0) send_control(OP_DRAIN, 32'd6);
  endtask

  task automatic test_backpressure();
    set_idling(0, 0);
    configure(0, 0, 0, 1'b1, 1'b1);
    // hold the output long enough to back up the input
    hold_trigger = ~hold_trigger;
    repeat (40) send_packet(1'($urandom_range(1)), TimeW'($urandom()));
  endtask

  task automatic test_random_traffic(int unsigned send_pct, int unsigned recv_pct,
                                     int unsigned count);
    int unsigned delay, cap, flush, roll;
    set_idling(send_pct, recv_pct);
    for (int s = 0; s < 3; s++) begin
      case ($urandom_range(3))
        0:       delay = 0;
        1:       delay = $urandom_range(1, 64);
        2:       delay = $urandom_range(0, 99999);
        default: delay = 99999;
      endcase
      case ($urandom_range(3))
        0:       cap = 0;
        1:       cap = 1;
        2:       cap = $urandom_range(2, 16);
        default: cap = $urandom_range(17, 4096);
      endcase
      case ($urandom_range(3))
        0:       flush = 0;
        1:       flush = 1;
        2:       flush = $urandom_range(2, 63);
        default: flush = 64;
      endcase
      configure(delay, cap, flush, 1'($urandom_range(1)), 1'($urandom_range(1)));
      clock_ms = TimeW'($urandom());
      for (int i = 0; i < count / 3; i++) begin
        if ($urandom_range(99) < 5) clock_ms = TimeW'($urandom());
        else clock_ms += TimeW'($urandom_range(0, delay / 8 + 4));
        roll = $urandom_range(99);
        if (roll < 70) send_packet(1'($urandom_range(1)), clock_ms);
        else if (roll < 85) send_control(OP_TICK, clock_ms);
        else if (roll < 93) send_control(OP_DRAIN, clock_ms);
        else send_control(OP_SPARE, clock_ms);
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (hold_trigger != hold_seen) begin
      hold_seen = hold_trigger;
      hold_left = LongHold;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    release_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      releases_seen++;
      if (release_q.size() == 0) begin
        report_mismatch("release with nothing pending, tag", packet_tag_res_o, 0);
      end else begin
        want = release_q.pop_front();
        if (packet_tag_res_o !== want.tag)
          report_mismatch("packet_tag_res", packet_tag_res_o, want.tag);
        if (cause_o !== want.cause) report_mismatch("cause", cause_o, want.cause);
        if (held_count_o !== want.held) report_mismatch("held_count", held_count_o, want.held);
        if (last_o !== want.last) report_mismatch("last", last_o, want.last);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WatchdogLimit) begin
      $display("Watchdog: no transfer for %0d cycles, %0d releases pending",
               WatchdogLimit, release_q.size());
      $display("timed_packet_delay_queue_core verification failed");
      $finish;
    end
  end

  initial begin
    cfg_shadow.delay_ms       = DelayReset;
    cfg_shadow.capacity       = '0;
    cfg_shadow.flush_count    = '0;
    cfg_shadow.delay_inbound  = 1'b1;
    cfg_shadow.delay_outbound = 1'b1;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_expiry();
    test_directions();
    test_flush();
    test_burst_limit();
    test_large_capacity();
    test_backpressure();
    test_random_traffic(23, 85, 36);
    test_random_traffic(85, 23, 36);
    test_random_traffic(0, 0, 36);
    settle();
    $display("Run summary: %0d items in, %0d releases checked, %0d register writes, %0d bad",
             items_sent, releases_seen, reg_writes, mismatches);
    $display("Covered pass-through, expiry across time wrap, flush, drain, burst cap, stalls");
    if (mismatches == 0) begin
      $display("timed_packet_delay_queue_core verification clean");
    end else begin
      $display("timed_packet_delay_queue_core verification failed");
    end
    $finish;
  end

endmodule

### timed_packet_delay_queue_core.f
sv/tpdq_pkg.sv
sv/tpdq_cfg.sv
sv/timed_packet_delay_queue_core.sv
verif/testbench.sv
